FILE: design/kpd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package kpd_pkg;

   localparam int KEY_ROWS_DEFAULT    = 4;
   localparam int KEY_COLUMNS_DEFAULT = 4;

   localparam int ROW_W  = 4;
   localparam int DRV_W  = 4;
   localparam int CODE_W = 5;
   localparam int MAP_W  = 16;
   localparam int CNT_W  = 4;

   localparam logic [CNT_W-1:0] THRESHOLD_RESET = 4'd10;

   typedef enum logic [0:0] {
      OP_SCAN = 1'b0,
      OP_READ = 1'b1
   } opcode_type;

   // Request as seen by the debounce logic in the cycle it is executed.
   typedef struct packed {
      logic             fire;
      opcode_type       opcode;
      logic [ROW_W-1:0] rows;
   } step_type;

   typedef struct packed {
      logic [DRV_W-1:0]  column_drive;
      logic [CODE_W-1:0] key_code;
      logic [MAP_W-1:0]  pressed_map;
   } result_type;

endpackage

`default_nettype wire

FILE: design/kpd_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface kpd_req_if;
   import kpd_pkg::*;
   logic             valid;
   logic             ready;
   logic             opcode;
   logic [ROW_W-1:0] row_levels;

   modport source (output valid, output opcode, output row_levels, input ready);
   modport sink   (input valid, input opcode, input row_levels, output ready);
endinterface

interface kpd_rsp_if;
   import kpd_pkg::*;
   logic              valid;
   logic              ready;
   logic [DRV_W-1:0]  column_drive;
   logic [CODE_W-1:0] key_code;
   logic [MAP_W-1:0]  pressed_map;

   modport source (output valid, output column_drive, output key_code, output pressed_map,
                   input ready);
   modport sink   (input valid, input column_drive, input key_code, input pressed_map,
                   output ready);
endinterface

interface kpd_csr_if;
   import kpd_pkg::*;
   logic             valid;
   logic             ready;
   logic [CNT_W-1:0] debounce_threshold;

   modport source (output valid, output debounce_threshold, input ready);
   modport sink   (input valid, input debounce_threshold, output ready);
endinterface

`default_nettype wire

FILE: design/matrix_keypad_scan_debounce.sv
`timescale 1ns / 1ps
`default_nettype none

// A request accepted into the input register executes once the response register is free
// or is being emptied, and its result is then loaded into the response register.
// One request per cycle while responses are taken. While a response waits, the input
// register takes one more request and holds the input off until the response is taken.
// Reset (synchronous, active high) clears all debounce counters, pressed flags,
// the latched key and the scan column, and sets the debounce threshold to 10.
module matrix_keypad_scan_debounce #(
   parameter int KEY_ROWS    = kpd_pkg::KEY_ROWS_DEFAULT,
   parameter int KEY_COLUMNS = kpd_pkg::KEY_COLUMNS_DEFAULT
) (
   input wire logic   clock,
   input wire logic   reset,
   kpd_req_if.sink    req_bus,
   kpd_rsp_if.source  rsp_bus,
   kpd_csr_if.sink    csr_bus
);
   import kpd_pkg::*;

   logic             in_valid_ff;
   logic             in_valid_in;
   opcode_type       in_op_ff;
   logic [ROW_W-1:0] in_rows_ff;
   logic             out_valid_ff;
   logic             out_valid_in;
   result_type       out_ff;
   result_type       result;
   logic             advance;
   logic             fire;
   logic [CNT_W-1:0] threshold_ff;
   step_type         step;

   assign advance       = !out_valid_ff || rsp_bus.ready;
   assign fire          = in_valid_ff && advance;
   assign req_bus.ready = !in_valid_ff || advance;
   assign csr_bus.ready = 1'b1;

   assign in_valid_in  = req_bus.ready ? req_bus.valid : in_valid_ff;
   assign out_valid_in = fire ? 1'b1 : (rsp_bus.ready ? 1'b0 : out_valid_ff);

   assign step.fire   = fire;
   assign step.opcode = in_op_ff;
   assign step.rows   = in_rows_ff;

   kpd_debounce #(
      .KEY_ROWS    (KEY_ROWS),
      .KEY_COLUMNS (KEY_COLUMNS)
   ) u_debounce (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .threshold (threshold_ff),
      .result    (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         threshold_ff <= THRESHOLD_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (csr_bus.valid) begin
            threshold_ff <= csr_bus.debounce_threshold;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_bus.valid && req_bus.ready) begin
         in_op_ff   <= opcode_type'(req_bus.opcode);
         in_rows_ff <= req_bus.row_levels;
      end
      if (fire) begin
         out_ff <= result;
      end
   end

   assign rsp_bus.valid        = out_valid_ff;
   assign rsp_bus.column_drive = out_ff.column_drive;
   assign rsp_bus.key_code     = out_ff.key_code;
   assign rsp_bus.pressed_map  = out_ff.pressed_map;

   pending_kept_a: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff)
      else $error("stalled request dropped from the input register");

   fire_gives_rsp_a: assert property (@(posedge clock) disable iff (reset)
      fire |=> out_valid_ff)
      else $error("executed request produced no response");

   no_overrun_a: assert property (@(posedge clock) disable iff (reset)
      !(req_bus.valid && req_bus.ready && in_valid_ff && !advance))
      else $error("request accepted into a full input register");

endmodule

`default_nettype wire

FILE: design/kpd_debounce.sv
`timescale 1ns / 1ps
`default_nettype none

module kpd_debounce #(
   parameter int KEY_ROWS    = kpd_pkg::KEY_ROWS_DEFAULT,
   parameter int KEY_COLUMNS = kpd_pkg::KEY_COLUMNS_DEFAULT
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire kpd_pkg::step_type           step,
   input  wire logic [kpd_pkg::CNT_W-1:0]   threshold,
   output kpd_pkg::result_type              result
);
   import kpd_pkg::*;

   localparam int KEY_TOTAL = KEY_ROWS * KEY_COLUMNS;
   localparam int COL_IDX_W = (KEY_COLUMNS > 1) ? $clog2(KEY_COLUMNS) : 1;
   localparam logic [COL_IDX_W-1:0] LAST_COL = COL_IDX_W'(KEY_COLUMNS - 1);

   logic                  scan;
   logic                  read;
   logic [KEY_ROWS-1:0]   rows_ext;
   logic [KEY_TOTAL-1:0]  confirm;
   logic [KEY_TOTAL-1:0]  flag_next;
   logic [COL_IDX_W-1:0]  col_ff;
   logic [COL_IDX_W-1:0]  col_in;
   logic [CODE_W-1:0]     latch_ff;
   logic [CODE_W-1:0]     latch_in;
   logic [CODE_W-1:0]     code_out;
   logic [CODE_W-1:0]     new_code;
   logic [KEY_COLUMNS-1:0] drive_full;

   assign scan     = step.fire && (step.opcode == OP_SCAN);
   assign read     = step.fire && (step.opcode == OP_READ);
   assign rows_ext = KEY_ROWS'(step.rows);

   // One up/down counter and flag per key; only the keys of the scanned column move.
   for (genvar r = 0; r < KEY_ROWS; r++) begin : g_row
      for (genvar c = 0; c < KEY_COLUMNS; c++) begin : g_col
         localparam int K = r * KEY_COLUMNS + c;
         logic [CNT_W-1:0] count_ff;
         logic [CNT_W-1:0] count_in;
         logic             flag_ff;
         logic             flag_in;
         logic             active;
         logic             down;

         assign active = scan && (col_ff == COL_IDX_W'(c));
         assign down   = !rows_ext[KEY_ROWS-1-r];

         always_comb begin
            count_in   = count_ff;
            flag_in    = flag_ff;
            confirm[K] = 1'b0;
            if (active && down) begin
               if (count_ff < threshold) begin
                  count_in = count_ff + 1'b1;
                  if (count_in == threshold) begin
                     flag_in    = 1'b1;
                     confirm[K] = 1'b1;
                  end
               end
            end else if (active && count_ff != '0) begin
               count_in = count_ff - 1'b1;
               if (count_in == '0) begin
                  flag_in = 1'b0;
               end
            end
         end

         assign flag_next[K] = flag_in;

         always_ff @(posedge clock) begin
            if (reset) begin
               count_ff <= '0;
               flag_ff  <= 1'b0;
            end else begin
               count_ff <= count_in;
               flag_ff  <= flag_in;
            end
         end
      end
   end

   // The highest confirming key wins, since later rows overwrite earlier ones.
   always_comb begin
      new_code = '0;
      for (int k = 0; k < KEY_TOTAL; k++) begin
         if (confirm[k]) begin
            new_code = CODE_W'(k + 1);
         end
      end
   end

   always_comb begin
      latch_in = latch_ff;
      code_out = '0;
      col_in   = col_ff;
      if (read) begin
         code_out = latch_ff;
         latch_in = '0;
      end else if (scan) begin
         if (confirm != '0) begin
            latch_in = new_code;
         end
         col_in = (col_ff == LAST_COL) ? '0 : col_ff + 1'b1;
      end
   end

   always_comb begin
      for (int c = 0; c < KEY_COLUMNS; c++) begin
         drive_full[KEY_COLUMNS-1-c] = (col_in != COL_IDX_W'(c));
      end
   end

   assign result.column_drive = DRV_W'(drive_full);
   assign result.key_code     = code_out;
   assign result.pressed_map  = MAP_W'(flag_next);

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff   <= '0;
         latch_ff <= '0;
      end else begin
         col_ff   <= col_in;
         latch_ff <= latch_in;
      end
   end

   latch_range_a: assert property (@(posedge clock) disable iff (reset)
      (KEY_TOTAL >= 32) || (latch_ff <= CODE_W'(KEY_TOTAL)))
      else $error("latched key code out of range");

   read_clears_a: assert property (@(posedge clock) disable iff (reset)
      read |=> (latch_ff == '0))
      else $error("read did not clear the latched key");

   read_holds_column_a: assert property (@(posedge clock) disable iff (reset)
      !scan |=> (col_ff == $past(col_ff)))
      else $error("column moved without a scan");

endmodule

`default_nettype wire

FILE: test/matrix_keypad_scan_debounce_tb.sv
`timescale 1ns / 1ps
`default_nettype none

module matrix_keypad_scan_debounce_tb;
   import kpd_pkg::*;

   typedef enum logic {ROW_REQ, ROW_CSR} row_kind_type;

   typedef struct packed {
      row_kind_type     kind;
      opcode_type       op;
      logic [ROW_W-1:0] value;
      logic             typed;
      result_type       want;
   } script_row_type;

   localparam int KEYS         = KEY_ROWS_DEFAULT * KEY_COLUMNS_DEFAULT;
   localparam int N_DIRECTED   = 31;
   localparam int N_PHASES     = 8;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int DRAIN_CYCLES = 8;
   localparam int LONG_HOLD    = 120;
   localparam int MAX_GAP      = 18;

   localparam result_type UNTYPED = '0;

   localparam logic [CNT_W-1:0] PHASE_THRESHOLD [N_PHASES] =
      '{4'd2, 4'd15, 4'd1, 4'd6, 4'd0, 4'd9, 4'd3, 4'd12};
   localparam int PHASE_ITEMS [N_PHASES] = '{80, 200, 60, 80, 40, 90, 80, 120};

   logic clock;
   logic reset;

   kpd_req_if req_bus();
   kpd_rsp_if rsp_bus();
   kpd_csr_if csr_bus();

   matrix_keypad_scan_debounce DUT (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   // Predicted keypad state.
   logic [CNT_W-1:0]  debounce_cnt [KEYS];
   logic [MAP_W-1:0]  confirmed_keys;
   logic [CODE_W-1:0] latched_code;
   logic [1:0]        scan_col;
   logic [CNT_W-1:0]  threshold;

   result_type pending_results [$];

   int  mismatches        = 0;
   int  codes_returned    = 0;
   int  scans_sent        = 0;
   int  reads_sent        = 0;
   int  settings_used     = 0;
   bit  long_hold_pending = 0;
   bit  sender_steady     = 0;
   int unsigned cycle_count = 0;

   // Rows are typed in only where the response is obvious.
   script_row_type directed_rows [N_DIRECTED] = '{
      '{ROW_REQ, OP_READ, 4'h0, 1'b1, '{4'b0111, 5'd0, 16'h0000}},
      '{ROW_REQ, OP_SCAN, 4'hF, 1'b1, '{4'b1011, 5'd0, 16'h0000}},
      '{ROW_REQ, OP_SCAN, 4'hF, 1'b1, '{4'b1101, 5'd0, 16'h0000}},
      '{ROW_REQ, OP_SCAN, 4'hF, 1'b1, '{4'b1110, 5'd0, 16'h0000}},
      '{ROW_REQ, OP_SCAN, 4'hF, 1'b1, '{4'b0111, 5'd0, 16'h0000}},
      '{ROW_CSR, OP_SCAN, 4'd1, 1'b0, UNTYPED},
      '{ROW_REQ, OP_SCAN, 4'h0, 1'b0, UNTYPED},
      '{ROW_REQ, OP_READ, 4'h0, 1'b0, UNTYPED},
      '{ROW_REQ, OP_READ, 4'hF, 1'b1, '{4'b1011, 5'd0, 16'h1111}},
      '{ROW_REQ, OP_SCAN, 4'h7, 1'b0, UNTYPED},
      '{ROW_REQ, OP_SCAN, 4'hE, 1'b0, UNTYPED},
      '{ROW_REQ, OP_SCAN, 4'h0, 1'b0, UNTYPED},
      '{ROW_REQ, OP_READ, 4'h0, 1'b0, UNTYPED},
      '{ROW_CSR, OP_SCAN, 4'd3, 1'b0, UNTYPED},
      '{ROW_REQ, OP_SCAN, 4'hF, 1'b0, UNTYPED},
      '{ROW_REQ, OP_SCAN, 4'h7, 1'b0, UNTYPED},
      '{ROW_REQ, OP_SCAN, 4'hF, 1'b0, UNTYPED},
      '{ROW_REQ, OP_SCAN, 4'hF, 1'b0, UNTYPED},
      '{ROW_REQ, OP_SCAN, 4'hF, 1'b0, UNTYPED},
      '{ROW_REQ, OP_SCAN, 4'h7, 1'b0, UNTYPED},
      '{ROW_REQ, OP_READ, 4'h0, 1'b0, UNTYPED},
      '{ROW_CSR, OP_SCAN, 4'd1, 1'b0, UNTYPED},
      '{ROW_REQ, OP_SCAN, 4'hF, 1'b0, UNTYPED},
      '{ROW_REQ, OP_SCAN, 4'hF, 1'b0, UNTYPED},
      '{ROW_REQ, OP_SCAN, 4'hF, 1'b0, UNTYPED},
      '{ROW_REQ, OP_SCAN, 4'h7, 1'b0, UNTYPED},
      '{ROW_REQ, OP_READ, 4'h0, 1'b0, UNTYPED},
      '{ROW_CSR, OP_SCAN, 4'd0, 1'b0, UNTYPED},
      '{ROW_REQ, OP_SCAN, 4'h0, 1'b0, UNTYPED},
      '{ROW_REQ, OP_SCAN, 4'hA, 1'b0, UNTYPED},
      '{ROW_REQ, OP_READ, 4'h0, 1'b0, UNTYPED}
   };

   function automatic result_type advance_keypad(opcode_type op, logic [ROW_W-1:0] rows);
      result_type res;
      int k;
      res.key_code = '0;
      if (op == OP_READ) begin
         res.key_code = latched_code;
         latched_code = '0;
      end else begin
         for (int r = 0; r < KEY_ROWS_DEFAULT; r++) begin
            k = r * KEY_COLUMNS_DEFAULT + scan_col;
            // Row 0 is sensed on the top bit, and a low level means the key is down.
            if (!rows[ROW_W-1-r]) begin
               if (debounce_cnt[k] < threshold) begin
                  debounce_cnt[k] = debounce_cnt[k] + 1'b1;
                  if (debounce_cnt[k] == threshold) begin
                     confirmed_keys[k] = 1'b1;
                     latched_code = CODE_W'(k + 1);
                  end
               end
            end else if (debounce_cnt[k] != '0) begin
               debounce_cnt[k] = debounce_cnt[k] - 1'b1;
               if (debounce_cnt[k] == '0) confirmed_keys[k] = 1'b0;
            end
         end
         scan_col = scan_col + 1'b1;
      end
      res.column_drive = 4'b1111 & ~(4'b1000 >> scan_col);
      res.pressed_map = confirmed_keys;
      return res;
   endfunction

   task automatic offer_request(opcode_type op, logic [ROW_W-1:0] rows, logic typed,
                                result_type want);
      int gap;
      result_type predicted;
      if ($urandom_range(0, 29) == 0) sender_steady = !sender_steady;
      gap = sender_steady ? 0 : $urandom_range(0, MAX_GAP);
      if (gap > 0) begin
         req_bus.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid = 1'b1;
      req_bus.opcode = op;
      req_bus.row_levels = rows;
      @(posedge clock);
      while (req_bus.ready !== 1'b1) @(posedge clock);
      predicted = advance_keypad(op, rows);
      pending_results.push_back(typed ? want : predicted);
      if (op == OP_READ) reads_sent++;
      else scans_sent++;
      @(negedge clock);
   endtask

   // The threshold only changes once every response has come back.
   task automatic write_threshold(logic [CNT_W-1:0] value);
      req_bus.valid = 1'b0;
      while (pending_results.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      csr_bus.valid = 1'b1;
      csr_bus.debounce_threshold = value;
      @(posedge clock);
      while (csr_bus.ready !== 1'b1) @(posedge clock);
      threshold = value;
      settings_used++;
      @(negedge clock);
      csr_bus.valid = 1'b0;
   endtask

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("%0t: timed out after %0d cycles", $time, cycle_count);
      $display("FAIL");
      $finish;
   end

   initial begin : response_side
      int wait_cycles;
      bit steady;
      result_type want;
      steady = 0;
      rsp_bus.ready = 1'b0;
      @(negedge clock);
      while (reset !== 1'b0) @(negedge clock);
      forever begin
         if ($urandom_range(0, 29) == 0) steady = !steady;
         wait_cycles = steady ? 0 : $urandom_range(0, MAX_GAP);
         if (long_hold_pending) begin
            wait_cycles = LONG_HOLD;
            long_hold_pending = 0;
         end
         if (wait_cycles > 0) begin
            rsp_bus.ready = 1'b0;
            repeat (wait_cycles) @(negedge clock);
         end
         rsp_bus.ready = 1'b1;
         @(posedge clock);
         while (rsp_bus.valid !== 1'b1) @(posedge clock);
         if (rsp_bus.key_code != '0) codes_returned++;
         if (pending_results.size() == 0) begin
            mismatches++;
            $display("%0t: unexpected response: drive %b code %0d map %h", $time,
                     rsp_bus.column_drive, rsp_bus.key_code, rsp_bus.pressed_map);
         end else begin
            want = pending_results.pop_front();
            if (rsp_bus.column_drive !== want.column_drive) begin
               mismatches++;
               $display("%0t: column_drive expected %b actual %b", $time,
                        want.column_drive, rsp_bus.column_drive);
            end
            if (rsp_bus.key_code !== want.key_code) begin
               mismatches++;
               $display("%0t: key_code expected %0d actual %0d", $time,
                        want.key_code, rsp_bus.key_code);
            end
            if (rsp_bus.pressed_map !== want.pressed_map) begin
               mismatches++;
               $display("%0t: pressed_map expected %h actual %h", $time,
                        want.pressed_map, rsp_bus.pressed_map);
            end
         end
         @(negedge clock);
      end
   end

   initial begin : stimulus
      logic [ROW_W-1:0] rows;
      logic [MAP_W-1:0] held_keys;
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.opcode = OP_SCAN;
      req_bus.row_levels = '0;
      csr_bus.valid = 1'b0;
      csr_bus.debounce_threshold = '0;
      held_keys = '0;
      for (int k = 0; k < KEYS; k++) debounce_cnt[k] = '0;
      confirmed_keys = '0;
      latched_code = '0;
      scan_col = '0;
      threshold = THRESHOLD_RESET;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      for (int i = 0; i < N_DIRECTED; i++) begin
         if (directed_rows[i].kind == ROW_CSR) begin
            write_threshold(directed_rows[i].value);
         end else begin
            offer_request(directed_rows[i].op, directed_rows[i].value,
                          directed_rows[i].typed, directed_rows[i].want);
         end
      end

      for (int p = 0; p < N_PHASES; p++) begin
         write_threshold(PHASE_THRESHOLD[p]);
         // Stall the response side long enough for the block to back up its input.
         if (p == 1) long_hold_pending = 1;
         for (int i = 0; i < PHASE_ITEMS[p]; i++) begin
            // Keys are held long enough on average to get through the debounce.
            if ($urandom_range(0, 8 * threshold + 8) == 0) begin
               case ($urandom_range(0, 5))
                  0: held_keys = '0;
                  1: held_keys = '1;
                  default: held_keys = MAP_W'($urandom & $urandom);
               endcase
            end
            if ($urandom_range(0, 4) == 0) begin
               offer_request(OP_READ, ROW_W'($urandom), 1'b0, UNTYPED);
            end else begin
               for (int r = 0; r < KEY_ROWS_DEFAULT; r++) begin
                  rows[ROW_W-1-r] = !held_keys[r * KEY_COLUMNS_DEFAULT + scan_col];
               end
               if ($urandom_range(0, 7) == 0) rows = ROW_W'($urandom);
               else if ($urandom_range(0, 9) == 0) rows[$urandom_range(0, ROW_W-1)] ^= 1'b1;
               offer_request(OP_SCAN, rows, 1'b0, UNTYPED);
            end
         end
      end

      req_bus.valid = 1'b0;
      while (pending_results.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      $display("Sent %0d scan ticks and %0d reads over %0d threshold settings.",
               scans_sent, reads_sent, settings_used);
      $display("%0d reads returned a key code; %0d mismatches found.",
               codes_returned, mismatches);
      if (mismatches == 0) $display("PASS");
      else $display("FAIL");
      $finish;
   end

endmodule

`default_nettype wire

FILE: matrix_keypad_scan_debounce.f
design/kpd_pkg.sv
design/kpd_if.sv
design/kpd_debounce.sv
design/matrix_keypad_scan_debounce.sv
test/matrix_keypad_scan_debounce_tb.sv
